// ===== rtl/i2da_pkg.sv =====
// Package for the decimal ASCII converter: controller state type and character constants.
// Depends on nothing; imported by int_to_decimal_ascii and by tb_top.
package i2da_pkg;

    // Width of the result beat's tdata: character code, character total, zero fill.
    localparam int CHAR_W     = 8;
    localparam int TOTAL_W    = 4;
    localparam int OUT_DATA_W = 16;

    // ASCII codes used in the text.
    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] MINUS_SIGN = 8'h2D;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

endpackage

// ===== rtl/int_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Depends on i2da_pkg for the state type and the character constants.
//
// Usage: the slave channel takes one number per beat, s_tdata holding the
// value in its low VALUE_WIDTH bits and s_tuser selecting unsigned (1) or
// signed two's complement (0) text. The master channel returns one character
// per beat, most significant digit first, with no leading zeros; a negative
// signed number starts with '-'. m_tlast marks the final character, which also
// carries the character count of the whole number.
// Operation: a number is converted by a shift-and-add-3 loop that takes one bit
// per cycle, then leading zero digits are dropped at one digit per cycle (at most
// NDIG-1 of them) and the character count is settled, then characters leave one
// per cycle while the receiver is ready. The dropped zeros and the digits always
// add up to NDIG.
// One number is worked on at a time; s_tready is high only while the
// controller is idle, which includes the time the last character of the
// previous number still waits in the output register.
// When the receiver stalls, the current character holds in the output register
// and the controller waits. Reset empties the output register and returns the
// controller to idle.
module int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32,
    localparam int IN_DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: value_bits in the low VALUE_WIDTH bits, zero fill above
    input  logic [IN_DATA_W-1:0]              s_tdata,
    // s_tuser: is_unsigned
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: char_code [7:0], char_total [11:8], zero fill [15:12]
    output logic [i2da_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import i2da_pkg::*;

    // Decimal digits needed for the largest unsigned value of the width.
    localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * NDIG;
    localparam int BIT_CW = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CW = $clog2(NDIG + 1);

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BIT_CW-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]      dig_cnt_reg, dig_cnt_next;
    logic                   neg_reg, neg_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;
    logic [TOTAL_W-1:0]     m_total_reg, m_total_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   is_last;

    // Magnitude of the incoming number; the most negative value maps to itself,
    // which is its correct magnitude when read as unsigned.
    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_neg   = !s_tuser && in_value[VALUE_WIDTH-1];
    assign in_mag   = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

    // Add 3 to every BCD digit of 5 or more before the next shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? (bcd_reg[i*4 +: 4] + 4'd3)
                                                             : bcd_reg[i*4 +: 4];
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !m_valid_reg || m_tready;
    assign is_last   = (dig_cnt_reg == DIG_CW'(1));

    // Next state and output register loading.
    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        neg_next     = neg_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_total_next = m_total_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mag_next     = in_mag;
                    neg_next     = in_neg;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CW'(VALUE_WIDTH);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                // One magnitude bit enters the BCD register per cycle.
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next     = mag_reg << 1;
                bit_cnt_next = bit_cnt_reg - BIT_CW'(1);
                if (bit_cnt_reg == BIT_CW'(1)) begin
                    dig_cnt_next = DIG_CW'(NDIG);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zero digits, keeping at least one digit.
                if (!is_last && top_digit == 4'd0) begin
                    bcd_next     = bcd_reg << 4;
                    dig_cnt_next = dig_cnt_reg - DIG_CW'(1);
                end else begin
                    total_next = TOTAL_W'(dig_cnt_reg) + {{(TOTAL_W-1){1'b0}}, neg_reg};
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = MINUS_SIGN;
                    m_last_next  = 1'b0;
                    m_total_next = '0;
                    state_next   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = DIGIT_ZERO + {4'b0000, top_digit};
                    m_last_next  = is_last;
                    m_total_next = is_last ? total_reg : '0;
                    bcd_next     = bcd_reg << 4;
                    dig_cnt_next = dig_cnt_reg - DIG_CW'(1);
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        total_reg   <= total_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
        m_total_reg <= m_total_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(OUT_DATA_W-CHAR_W-TOTAL_W){1'b0}}, m_total_reg, m_char_reg};

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for int_to_decimal_ascii: numbers go in, ASCII characters come out.
// Depends on i2da_pkg for the character constants and widths and on the converter RTL.
// Each accepted number is converted here too, and every output beat is checked in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2da_pkg::*;

    localparam int VALUE_W     = 32;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int SETTLE_WAIT = 60;

    // One expected character beat.
    typedef struct {
        logic [CHAR_W-1:0]  code;
        logic               is_last;
        logic [TOTAL_W-1:0] count;
    } char_beat_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [VALUE_W-1:0]    s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    char_beat_t pending_chars[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;
    int         hold_off_left = 0;

    int_to_decimal_ascii #(.VALUE_WIDTH(VALUE_W)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver side: a requested hold-off wins, otherwise stall at the phase's rate.
    always @(negedge aclk) begin
        if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Expected text of one number: optional minus sign, then digits from the most
    // significant one, with the character count on the final digit.
    function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                         input logic as_unsigned);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digits[24];
        int                 n_digits;
        int                 total;
        logic               negative;
        negative  = !as_unsigned && value[VALUE_W-1];
        // The most negative value negates to itself, which is the right magnitude.
        magnitude = negative ? (~value + 1'b1) : value;
        n_digits  = 0;
        do begin
            digits[n_digits] = 4'(magnitude % 10);
            magnitude        = magnitude / 10;
            n_digits++;
        end while (magnitude != 0);
        total = n_digits + (negative ? 1 : 0);
        if (negative) begin
            pending_chars.push_back(char_beat_t'{code: MINUS_SIGN, is_last: 1'b0, count: '0});
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            pending_chars.push_back(char_beat_t'{
                code:    DIGIT_ZERO + CHAR_W'(digits[i]),
                is_last: (i == 0),
                count:   (i == 0) ? TOTAL_W'(total) : '0
            });
        end
    endfunction

    // Output check: every accepted beat against the oldest expected character.
    always @(posedge aclk) begin : check_chars
        char_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected beat: char_code %h, tlast %b", m_tdata[7:0], m_tlast);
                error_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[CHAR_W-1:0] !== want.code) begin
                    $error("char_code: expected %h, got %h", want.code, m_tdata[CHAR_W-1:0]);
                    error_count++;
                end
                if (m_tlast !== want.is_last) begin
                    $error("last_char: expected %b, got %b", want.is_last, m_tlast);
                    error_count++;
                end
                if (m_tdata[CHAR_W +: TOTAL_W] !== want.count) begin
                    $error("char_total: expected %0d, got %0d",
                           want.count, m_tdata[CHAR_W +: TOTAL_W]);
                    error_count++;
                end
                if (m_tdata[OUT_DATA_W-1:CHAR_W+TOTAL_W] !== '0) begin
                    $error("tdata fill: expected 0, got %h",
                           m_tdata[OUT_DATA_W-1:CHAR_W+TOTAL_W]);
                    error_count++;
                end
            end
        end
    end

    // Offers one number, with random idle cycles first, and waits for its beat.
    task automatic send_number(input logic [VALUE_W-1:0] value, input logic as_unsigned);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= as_unsigned;
        do @(posedge aclk); while (!s_tready);
        predict_text(value, as_unsigned);
    endtask

    task automatic drain_outputs();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    // Field extremes, zero in both modes, the most negative value and digit-count edges.
    task automatic test_edge_values();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_number(32'd0, 1'b0);
        send_number(32'd0, 1'b1);
        send_number(32'd1, 1'b0);
        send_number(32'd9, 1'b1);
        send_number(32'd10, 1'b0);
        send_number(32'd99, 1'b1);
        send_number(32'd100, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'hFFFF_FFFF, 1'b1);
        send_number(32'h8000_0000, 1'b0);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'h7FFF_FFFF, 1'b0);
        send_number(32'h7FFF_FFFF, 1'b1);
        send_number(-32'sd10, 1'b0);
        send_number(-32'sd9, 1'b0);
        send_number(32'd999_999_999, 1'b0);
        send_number(32'd1_000_000_000, 1'b1);
        send_number(-32'sd999_999_999, 1'b0);
        send_number(32'hAAAA_AAAA, 1'b1);
        send_number(32'h5555_5555, 1'b0);
        drain_outputs();
    endtask

    // Random numbers spread over all lengths, both signs and both modes.
    task automatic test_random_stream(input int n_items, input int idle_pct, input int stall_pct);
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] power;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n_items) begin
            value = $urandom;
            case ($urandom_range(3))
                0: value = value >> $urandom_range(31);
                1: value = -(value >> $urandom_range(31));
                2: begin
                    // Just around a power of ten, where the digit count changes.
                    power = 1;
                    repeat ($urandom_range(9)) power = power * 10;
                    value = power - $urandom_range(1);
                    if ($urandom_range(1)) value = -value;
                end
                default: ;
            endcase
            send_number(value, 1'($urandom_range(1)));
        end
        drain_outputs();
    endtask

    // The receiver holds off for a long stretch while numbers keep coming,
    // so the converter fills up and drops s_tready.
    task automatic test_output_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        @(posedge aclk);
        hold_off_left = 400;
        repeat (10) send_number($urandom, 1'($urandom_range(1)));
        drain_outputs();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_edge_values();
        test_random_stream(95, 0, 0);
        test_random_stream(95, 77, 0);
        test_random_stream(95, 0, 77);
        test_random_stream(95, 18, 18);
        test_output_hold_off();

        repeat (SETTLE_WAIT) @(posedge aclk);
        if (pending_chars.size() != 0) begin
            $error("%0d expected characters never arrived", pending_chars.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
